// File: rtl/core/assert_macros.svh
// Assertion macros shared by the frame pacer RTL.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication check failed");

// Expression holds at every clock edge outside reset.
`define ASSERT_HOLDS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("%m: invariant check failed");

`endif

// File: rtl/core/fprm_pkg.sv
// Types and constants for the frame pacer / rate meter.
// No dependencies; used by the interfaces, divider, datapath, controller and top level.
package fprm_pkg;

   localparam int WINDOW      = 100;
   localparam int FT_MAX      = 65535;
   localparam int MS_PER_S    = 1000;
   localparam int RATE_SCALE  = 256000;
   localparam int FPS_RESET   = 60;
   localparam int FALLBACK_Q8 = 60 * 256;

   localparam int FPS_W   = 10;
   localparam int NOW_W   = 32;
   localparam int DELAY_W = 10;
   localparam int FT_W    = 16;
   localparam int RATE_W  = 25;

   localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CNT_W  = $clog2(WINDOW + 1);
   localparam int SUM_W  = $clog2(WINDOW * FT_MAX + 1);
   localparam int NUM_W  = $clog2(RATE_SCALE * WINDOW + 1);
   localparam int QCNT_W = $clog2(NUM_W + 1);

   typedef enum logic {
      OP_BEGIN = 1'b0,
      OP_END   = 1'b1
   } op_type;

   typedef enum logic {
      DIV_PERIOD = 1'b0,
      DIV_RATE   = 1'b1
   } div_sel_type;

   typedef struct packed {
      logic        take_begin;
      logic        take_end;
      logic        div_start;
      div_sel_type div_sel;
      logic        take_delay;
      logic        take_endat;
      logic        take_ft;
      logic        commit;
      logic        load_out;
   } dp_cmd_type;

   typedef struct packed {
      logic div_done;
      logic sum_zero;
   } dp_sts_type;

endpackage

// File: rtl/core/fprm_req_if.sv
// Input channel: frame begin/end events with a millisecond timestamp.
// Depends on fprm_pkg.
interface fprm_req_if
   import fprm_pkg::*;
   ();
   logic             valid;
   logic             ready;
   op_type           op;
   logic [NOW_W-1:0] now_ms;

   modport source (output valid, output op, output now_ms, input ready);
   modport sink   (input valid, input op, input now_ms, output ready);
endinterface

// File: rtl/core/fprm_rsp_if.sv
// Result channel: pacing delay, frame time and averaged rate.
// Depends on fprm_pkg.
interface fprm_rsp_if
   import fprm_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [DELAY_W-1:0] delay_ms;
   logic [FT_W-1:0]    frame_time_ms;
   logic [RATE_W-1:0]  fps_q8;

   modport source (output valid, output delay_ms, output frame_time_ms, output fps_q8,
                   input ready);
   modport sink   (input valid, input delay_ms, input frame_time_ms, input fps_q8,
                   output ready);
endinterface

// File: rtl/core/fprm_csr_if.sv
// Configuration write channel carrying the target frame rate.
// Depends on fprm_pkg.
interface fprm_csr_if
   import fprm_pkg::*;
   ();
   logic             valid;
   logic             ready;
   logic [FPS_W-1:0] max_fps;

   modport source (output valid, output max_fps, input ready);
   modport sink   (input valid, input max_fps, output ready);
endinterface

// File: rtl/core/fprm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fprm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 100
) (
   input  logic                                      clock,
   input  logic                                      we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                          wdata,
   input  logic                                      re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                          rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

// File: rtl/core/fprm_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on fprm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fprm_div
   import fprm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] dividend,
   input  logic [SUM_W-1:0] divisor,
   output logic             busy,
   output logic             done,
   output logic [NUM_W-1:0] quotient
);
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0]  quo_ff, quo_in;
   logic [SUM_W-1:0]  rem_ff, rem_in;
   logic [SUM_W-1:0]  dsr_ff, dsr_in;
   logic [SUM_W:0]    trial;
   logic              fits;

   // shift in the next dividend bit and try to subtract
   assign trial = {rem_ff, quo_ff[NUM_W-1]};
   assign fits  = (trial >= {1'b0, dsr_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = QCNT_W'(NUM_W);
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? SUM_W'(trial - {1'b0, dsr_ff}) : trial[SUM_W-1:0];
         quo_in = {quo_ff[NUM_W-2:0], fits};
         cnt_in = cnt_ff - QCNT_W'(1);
         if (cnt_ff == QCNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;

   `ASSERT_IMP(a_start_idle, clock, reset, start, !busy_ff)
   `ASSERT_IMP(a_done_after_busy, clock, reset, done_ff, !busy_ff)
endmodule

// File: rtl/core/fprm_dp.sv
// Datapath: timestamps, pacing delay, frame-time ring with running sum, rate.
// Depends on fprm_pkg, fprm_ram, fprm_div and assert_macros.svh.
`include "assert_macros.svh"

module fprm_dp
   import fprm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  dp_cmd_type         cmd,
   output dp_sts_type         sts,
   input  logic [NOW_W-1:0]   req_now_ms,
   input  logic               csr_valid,
   input  logic [FPS_W-1:0]   csr_max_fps,
   output logic               csr_ready,
   output logic [DELAY_W-1:0] rsp_delay_ms,
   output logic [FT_W-1:0]    rsp_frame_time_ms,
   output logic [RATE_W-1:0]  rsp_fps_q8
);
   logic [FPS_W-1:0]   max_fps_ff;
   logic [NOW_W-1:0]   start_ff, now_ff, elapsed_ff, prev_end_ff, end_at_ff;
   logic               first_seen_ff;
   logic [DELAY_W-1:0] delay_ff, delay_in;
   logic [FT_W-1:0]    ft_ff, ft_in;
   logic [SLOT_W-1:0]  slot_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [SUM_W-1:0]   sum_ff;
   logic [DELAY_W-1:0] out_delay_ff;
   logic [FT_W-1:0]    out_ft_ff;
   logic [RATE_W-1:0]  out_rate_ff;

   logic [FPS_W-1:0]   fps_div;
   logic [NUM_W-1:0]   div_dividend;
   logic [SUM_W-1:0]   div_divisor;
   logic [NUM_W-1:0]   quotient;
   logic               div_busy;
   logic               div_done;
   logic [NOW_W-1:0]   period;
   logic [NOW_W-1:0]   diff;
   logic [FT_W-1:0]    ring_rdata;
   logic [FT_W-1:0]    old_ft;
   logic               ring_full;

   assign fps_div = (max_fps_ff == '0) ? FPS_W'(1) : max_fps_ff;

   always_comb begin
      if (cmd.div_sel == DIV_PERIOD) begin
         div_dividend = NUM_W'(MS_PER_S);
         div_divisor  = SUM_W'(fps_div);
      end else begin
         div_dividend = NUM_W'(RATE_SCALE) * NUM_W'(cnt_ff);
         div_divisor  = sum_ff;
      end
   end

   fprm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (quotient)
   );

   fprm_ram #(
      .WIDTH (FT_W),
      .DEPTH (WINDOW)
   ) u_ring (
      .clock (clock),
      .we    (cmd.commit),
      .waddr (slot_ff),
      .wdata (ft_ff),
      .re    (cmd.take_end),
      .raddr (slot_ff),
      .rdata (ring_rdata)
   );

   // period is at most 1000, so the low quotient bits carry it
   assign period = NOW_W'(quotient[DELAY_W-1:0]);
   assign delay_in = (period > elapsed_ff) ? DELAY_W'(period - elapsed_ff) : '0;

   assign diff = end_at_ff - prev_end_ff;
   always_comb begin
      if (!first_seen_ff) begin
         ft_in = '0;
      end else if (diff > NOW_W'(FT_MAX)) begin
         ft_in = FT_W'(FT_MAX);
      end else begin
         ft_in = diff[FT_W-1:0];
      end
   end

   // slots are filled in order, so an unwritten slot is only seen before the ring fills
   assign ring_full = (cnt_ff == CNT_W'(WINDOW));
   assign old_ft    = ring_full ? ring_rdata : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_fps_ff    <= FPS_W'(FPS_RESET);
         start_ff      <= '0;
         prev_end_ff   <= '0;
         first_seen_ff <= 1'b0;
         slot_ff       <= '0;
         cnt_ff        <= '0;
         sum_ff        <= '0;
      end else begin
         if (csr_valid) begin
            max_fps_ff <= csr_max_fps;
         end
         if (cmd.take_begin) begin
            start_ff <= req_now_ms;
         end
         if (cmd.take_ft) begin
            prev_end_ff   <= end_at_ff;
            first_seen_ff <= 1'b1;
         end
         if (cmd.commit) begin
            sum_ff  <= sum_ff - SUM_W'(old_ft) + SUM_W'(ft_ff);
            slot_ff <= (slot_ff == SLOT_W'(WINDOW - 1)) ? '0 : slot_ff + SLOT_W'(1);
            if (!ring_full) begin
               cnt_ff <= cnt_ff + CNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_end) begin
         now_ff     <= req_now_ms;
         elapsed_ff <= req_now_ms - start_ff;
      end
      if (cmd.take_delay) begin
         delay_ff <= delay_in;
      end
      if (cmd.take_endat) begin
         end_at_ff <= now_ff + NOW_W'(delay_ff);
      end
      if (cmd.take_ft) begin
         ft_ff <= ft_in;
      end
      if (cmd.load_out) begin
         out_delay_ff <= delay_ff;
         out_ft_ff    <= ft_ff;
         out_rate_ff  <= (sum_ff == '0) ? RATE_W'(FALLBACK_Q8) : RATE_W'(quotient);
      end
   end

   assign sts.div_done = div_done;
   assign sts.sum_zero = (sum_ff == '0);

   assign csr_ready         = 1'b1;
   assign rsp_delay_ms      = out_delay_ff;
   assign rsp_frame_time_ms = out_ft_ff;
   assign rsp_fps_q8        = out_rate_ff;

   `ASSERT_HOLDS(a_cnt_range, clock, reset, cnt_ff <= CNT_W'(WINDOW))
   `ASSERT_HOLDS(a_slot_range, clock, reset, slot_ff < SLOT_W'(WINDOW))
   `ASSERT_HOLDS(a_sum_bound, clock, reset, sum_ff <= SUM_W'(cnt_ff) * SUM_W'(FT_MAX))
   `ASSERT_IMP(a_cmd_div_idle, clock, reset, cmd.take_ft || cmd.commit, !div_busy)
endmodule

// File: rtl/core/fprm_ctrl.sv
// Sequencer for the frame pacer: handshakes and datapath command steps.
// Depends on fprm_pkg.
module fprm_ctrl
   import fprm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  op_type     req_op,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output dp_cmd_type cmd,
   input  dp_sts_type sts
);
   typedef enum logic [7:0] {
      S_IDLE      = 8'b0000_0001,
      S_PDIV_WAIT = 8'b0000_0010,
      S_ENDAT     = 8'b0000_0100,
      S_FT        = 8'b0000_1000,
      S_COMMIT    = 8'b0001_0000,
      S_RDIV_GO   = 8'b0010_0000,
      S_RDIV_WAIT = 8'b0100_0000,
      S_PUBLISH   = 8'b1000_0000
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.div_sel = DIV_PERIOD;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_op == OP_END) begin
                  cmd.take_end  = 1'b1;
                  cmd.div_start = 1'b1;
                  state_in      = S_PDIV_WAIT;
               end else begin
                  cmd.take_begin = 1'b1;
               end
            end
         end
         S_PDIV_WAIT: begin
            if (sts.div_done) begin
               cmd.take_delay = 1'b1;
               state_in       = S_ENDAT;
            end
         end
         S_ENDAT: begin
            cmd.take_endat = 1'b1;
            state_in       = S_FT;
         end
         S_FT: begin
            cmd.take_ft = 1'b1;
            state_in    = S_COMMIT;
         end
         S_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = S_RDIV_GO;
         end
         S_RDIV_GO: begin
            if (sts.sum_zero) begin
               state_in = S_PUBLISH;
            end else begin
               cmd.div_sel   = DIV_RATE;
               cmd.div_start = 1'b1;
               state_in      = S_RDIV_WAIT;
            end
         end
         S_RDIV_WAIT: begin
            if (sts.div_done) begin
               state_in = S_PUBLISH;
            end
         end
         S_PUBLISH: begin
            // wait for the output register to drain before overwriting it
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
endmodule

// File: rtl/core/frame_pacer_rate_meter_unit.sv
// Frame pacer and moving-average frame rate meter, top level.
// Begin item: taken with no result. End item: a result loads after the bit-serial divider
// runs once for the frame period and once for the rate (skipped when the window sum is
// zero), one quotient bit per cycle. The next beat is taken the cycle after the result
// loads; the load waits while rsp stalls, so no new item is taken until the last is done.
// Sync active-high reset clears state, sets max_fps to 60; no ring clear pass.
module frame_pacer_rate_meter_unit
   import fprm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   fprm_req_if.sink   req_chan,
   fprm_rsp_if.source rsp_chan,
   fprm_csr_if.sink   csr_chan
);
   dp_cmd_type cmd;
   dp_sts_type sts;

   fprm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_op    (req_chan.op),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   fprm_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_now_ms        (req_chan.now_ms),
      .csr_valid         (csr_chan.valid),
      .csr_max_fps       (csr_chan.max_fps),
      .csr_ready         (csr_chan.ready),
      .rsp_delay_ms      (rsp_chan.delay_ms),
      .rsp_frame_time_ms (rsp_chan.frame_time_ms),
      .rsp_fps_q8        (rsp_chan.fps_q8)
   );
endmodule
